FILE: hdl/shrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrr_pkg: shared types and constants for the server health round robin
// Field widths, action and status codes, sequencer states and cell control.
// ----------------------------------------------------------------------------
package shrr_pkg;

  localparam int IDX_W           = 5;   // server index / count width
  localparam int ACT_W           = 2;
  localparam int STAT_W          = 2;
  localparam int DEF_MAX_SERVERS = 16;

  localparam logic [IDX_W-1:0] COUNT_RESET = IDX_W'(16);

  localparam logic FLAG_ERR = 1'b1;
  localparam logic FLAG_OK  = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_MARK_ERR = 2'd0,
    ACT_MARK_OK  = 2'd1,
    ACT_FIND_ERR = 2'd2,
    ACT_PICK     = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FOUND  = 2'd1,
    ST_NONE   = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_SCAN,
    S_EMIT
  } state_t;

  // Broadcast to every cell
  typedef struct packed {
    logic stop;    // drop the token everywhere
    logic target;  // flag value the token looks for
    logic wr_val;  // flag value for a mark
  } cell_ctl_t;

endpackage

FILE: hdl/shrr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrr_req_if / shrr_rsp_if: valid/ready channels of the block
// One word per handshake; request carries action and server, response
// carries status and result index.
// ----------------------------------------------------------------------------
interface shrr_req_if;
  logic                         valid;
  logic                         ready;
  logic [shrr_pkg::ACT_W-1:0]   action;
  logic [shrr_pkg::IDX_W-1:0]   server;

  modport source (output valid, action, server, input ready);
  modport sink   (input valid, action, server, output ready);
endinterface

interface shrr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [shrr_pkg::STAT_W-1:0]  status;
  logic [shrr_pkg::IDX_W-1:0]   result_index;

  modport source (output valid, status, result_index, input ready);
  modport sink   (input valid, status, result_index, output ready);
endinterface

FILE: hdl/shrr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrr_cell: one server slot of the scan chain
// Holds the health flag and the scan token; the token moves to the next
// cell each cycle and wraps from the last server in use.
// ----------------------------------------------------------------------------
module shrr_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  shrr_pkg::cell_ctl_t        ctl,
  input  logic [shrr_pkg::IDX_W-1:0] cnt,
  input  logic                       inject,
  input  logic                       wr_en,
  input  logic                       tok_in,
  output logic                       tok,
  output logic                       last,
  output logic                       hit
);
  import shrr_pkg::*;

  // slots past the index range can never be addressed
  localparam bit               REACH   = (IDX < (1 << IDX_W) - 1);
  localparam logic [IDX_W-1:0] SLOT_NO = REACH ? IDX_W'(IDX + 1) : '0;

  logic flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= FLAG_OK;
    end else if (wr_en) begin
      flag <= ctl.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctl.stop) begin
      tok <= 1'b0;
    end else begin
      tok <= inject | tok_in;
    end
  end

  assign last = REACH && (cnt == SLOT_NO);
  assign hit  = tok && (flag == ctl.target);

endmodule

FILE: hdl/server_health_round_robin_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// server_health_round_robin_unit: health table with round-robin server pick
// Per-server error flags in a chain of cells, scanned by a travelling token.
// ----------------------------------------------------------------------------
// Usage
//   req (sink): action + server word; rsp (source): status + result_index.
//   cfg_we/cfg_wdata write server_count; write only while the block is idle.
//   One request is worked at a time; req.ready is high only in idle, and a
//   request is taken even while the previous response still waits.
//   Steps from accept: mark, reject and pick with no servers go straight
//   to emit; find scans from server s up to the last server in use; pick
//   first reduces the pointer modulo count, then scans up to count servers.
//   During a scan the token steps one cell per clock.
//   The next word can be taken in the cycle after the result is registered.
//   Reset: all servers healthy, pointer zero, count 16, channels empty.
//   Receiver stall: the response word holds; the next result waits in the
//   emit state until the output register frees.
// ----------------------------------------------------------------------------
module server_health_round_robin_unit #(
  parameter int MAX_SERVERS = shrr_pkg::DEF_MAX_SERVERS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [shrr_pkg::IDX_W-1:0] cfg_wdata,
  shrr_req_if.sink                   req,
  shrr_rsp_if.source                 rsp
);
  import shrr_pkg::*;

  // effective count can never pass what the index field can name
  localparam int               CAP   = (MAX_SERVERS > (1 << IDX_W) - 1) ?
                                       (1 << IDX_W) - 1 : MAX_SERVERS;
  localparam logic [IDX_W-1:0] CAP_V = IDX_W'(CAP);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t            state, state_next;
  logic [IDX_W-1:0]  count_reg;    // as written
  logic [IDX_W-1:0]  cnt;          // effective count latched at accept
  logic [IDX_W-1:0]  cur_srv;      // round-robin pointer, 0 = none yet
  logic [IDX_W-1:0]  red;          // pointer being reduced modulo cnt
  logic [IDX_W-1:0]  pos;          // slot the token sits on (0-based)
  logic [IDX_W-1:0]  steps;        // pick steps left
  logic              is_pick;
  status_t           res_status;
  logic [IDX_W-1:0]  res_index;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0]  out_index;

  // --------------------------------------------------------------------------
  // Decode of the incoming word
  // --------------------------------------------------------------------------
  action_t          act;
  logic [IDX_W-1:0] cnt_eff;
  logic [IDX_W-1:0] srv_m1;
  logic             idx_ok;
  logic             accept;
  logic             is_mark;

  assign act     = action_t'(req.action);
  assign cnt_eff = (count_reg > CAP_V) ? CAP_V : count_reg;
  assign srv_m1  = req.server - IDX_W'(1);
  assign idx_ok  = (req.server != '0) && (req.server <= cnt_eff);
  assign accept  = req.valid && req.ready;
  assign is_mark = (act == ACT_MARK_ERR) || (act == ACT_MARK_OK);

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  cell_ctl_t              ctl;
  logic [MAX_SERVERS-1:0] tok_vec, last_vec, hit_vec, tok_in_vec;
  logic [MAX_SERVERS-1:0] inject_vec, wr_vec;
  logic                   hit;
  logic                   inject;
  logic [IDX_W-1:0]       inject_pos;
  logic                   scan_end;

  // cell 0 takes the token back from whichever cell is the last in use
  assign tok_in_vec[0] = |(tok_vec & last_vec);

  for (genvar k = 0; k < MAX_SERVERS; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign tok_in_vec[k] = tok_vec[k-1] & ~last_vec[k-1];
    end
    if (k < (1 << IDX_W)) begin : g_sel
      assign inject_vec[k] = inject && (inject_pos == IDX_W'(k));
      assign wr_vec[k]     = accept && is_mark && idx_ok && (srv_m1 == IDX_W'(k));
    end else begin : g_nosel
      assign inject_vec[k] = 1'b0;
      assign wr_vec[k]     = 1'b0;
    end

    shrr_cell #(.IDX(k)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .cnt    (cnt),
      .inject (inject_vec[k]),
      .wr_en  (wr_vec[k]),
      .tok_in (tok_in_vec[k]),
      .tok    (tok_vec[k]),
      .last   (last_vec[k]),
      .hit    (hit_vec[k])
    );
  end

  assign hit = |hit_vec;

  // find stops at the last server; pick stops after cnt visits
  assign scan_end = is_pick ? (steps == IDX_W'(1)) : (pos == cnt - IDX_W'(1));

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (act == ACT_PICK) begin
            state_next = (cnt_eff == '0) ? S_EMIT : S_REDUCE;
          end else if (idx_ok && (act == ACT_FIND_ERR)) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_REDUCE: begin
        if (red < cnt) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || scan_end) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    req.ready  = 1'b0;
    inject     = 1'b0;
    inject_pos = srv_m1;
    ctl.stop   = 1'b0;
    ctl.target = is_pick ? FLAG_OK : FLAG_ERR;
    ctl.wr_val = (act == ACT_MARK_ERR) ? FLAG_ERR : FLAG_OK;
    unique case (state)
      S_IDLE: begin
        // nothing is taken while reset is held
        req.ready = !rst;
        inject    = req.valid && idx_ok && (act == ACT_FIND_ERR);
      end
      S_REDUCE: begin
        inject     = (red < cnt);
        inject_pos = red;
      end
      S_SCAN: begin
        ctl.stop = hit || scan_end;
      end
      S_EMIT: begin
        ctl.stop = 1'b0;
      end
      default: ctl.stop = 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // State, pointer and datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_reg <= COUNT_RESET;
      cur_srv   <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        count_reg <= cfg_wdata;
      end
      if ((state == S_SCAN) && hit && is_pick) begin
        cur_srv <= pos + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cnt     <= cnt_eff;
          is_pick <= (act == ACT_PICK);
          red     <= cur_srv;
          pos     <= srv_m1;
          steps   <= cnt_eff;
          if (act == ACT_PICK) begin
            res_status <= ST_NONE;
          end else if (!idx_ok) begin
            res_status <= ST_REJECT;
          end else begin
            res_status <= ST_DONE;
          end
          res_index <= '0;
        end
      end
      S_REDUCE: begin
        if (red >= cnt) begin
          red <= red - cnt;
        end else begin
          pos <= red;
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_status <= ST_FOUND;
          res_index  <= pos + IDX_W'(1);
        end else if (scan_end) begin
          res_status <= ST_NONE;
          res_index  <= '0;
        end else begin
          pos   <= (pos == cnt - IDX_W'(1)) ? '0 : pos + IDX_W'(1);
          steps <= steps - IDX_W'(1);
        end
      end
      S_EMIT: begin
        red <= red;
      end
      default: red <= red;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_index  <= res_index;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_index = out_index;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("more than one scan token in the chain");

  a_scan_token: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> $onehot(tok_vec))
    else $error("scan running without a token");

  a_found_index: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_FOUND)) |-> (rsp.result_index != '0))
    else $error("found result with zero index");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted word left no work");

endmodule

FILE: bench/shrr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrr_checker: scoreboard for the server health round robin unit
// Watches the request, response and count-write ports, keeps its own copy
// of the health table and pointer, and compares every response word.
// ----------------------------------------------------------------------------
module shrr_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [shrr_pkg::IDX_W-1:0] cfg_wdata,
  shrr_req_if                        req,
  shrr_rsp_if                        rsp,
  output int                         fail_count,
  output int                         pending
);
  import shrr_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] index;
  } answer_t;

  answer_t          answer_q[$];
  logic [15:0]      err_flags;   // bit n: server n+1 in error
  logic [IDX_W-1:0] server_ptr;
  logic [IDX_W-1:0] count_reg;
  int               fails;

  // Works out one answer and applies its side effects to the table copy.
  function automatic answer_t serve_request(input action_t act,
                                            input logic [IDX_W-1:0] srv);
    answer_t ans;
    int      n;
    int      cur;
    int      nxt;
    bit      hit;
    n   = (count_reg > DEF_MAX_SERVERS) ? DEF_MAX_SERVERS : int'(count_reg);
    ans = '{status: ST_REJECT, index: '0};
    hit = 1'b0;
    if (act == ACT_PICK) begin
      ans.status = ST_NONE;
      cur = int'(server_ptr);
      for (int i = 0; i < n; i++) begin
        nxt = cur % n + 1;
        if (!hit && err_flags[nxt-1] == FLAG_OK) begin
          hit        = 1'b1;
          server_ptr = IDX_W'(nxt);
          ans.status = ST_FOUND;
          ans.index  = IDX_W'(nxt);
        end
        cur = nxt;
      end
    end else if (srv != '0 && int'(srv) <= n) begin
      case (act)
        ACT_MARK_ERR: begin
          err_flags[srv-1] = FLAG_ERR;
          ans.status = ST_DONE;
        end
        ACT_MARK_OK: begin
          err_flags[srv-1] = FLAG_OK;
          ans.status = ST_DONE;
        end
        default: begin
          ans.status = ST_NONE;
          for (int s = int'(srv); s <= n; s++) begin
            if (!hit && err_flags[s-1] == FLAG_ERR) begin
              hit        = 1'b1;
              ans.status = ST_FOUND;
              ans.index  = IDX_W'(s);
            end
          end
        end
      endcase
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      err_flags  = '0;
      server_ptr = '0;
      count_reg  = COUNT_RESET;
      fails      = 0;
      answer_q.delete();
    end else begin
      if (cfg_we) count_reg = cfg_wdata;
      // response first: a word taken on this edge cannot answer this edge's request
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected response word status=%0d index=%0d",
                   $time, rsp.status, rsp.result_index);
          fails++;
        end else begin
          want = answer_q.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp.status);
            fails++;
          end
          if (rsp.result_index !== want.index) begin
            $display("%0t: result_index expected %0d actual %0d",
                     $time, want.index, rsp.result_index);
            fails++;
          end
        end
      end
      if (req.valid && req.ready)
        answer_q.push_back(serve_request(action_t'(req.action), req.server));
    end
    fail_count <= fails;
    pending    <= answer_q.size();
  end

endmodule

FILE: bench/server_health_round_robin_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// server_health_round_robin_unit_test: regression top
// Drives directed and random request words across several server counts,
// stalls both channels at random, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module server_health_round_robin_unit_test;
  import shrr_pkg::*;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending;

  // calm: no idle cycles on that side for the current phase
  bit req_calm;
  bit rsp_calm;
  bit err_heavy;   // bias towards mark_error so picks run out of servers
  int live_count;  // effective server count, for shaping server indexes

  shrr_req_if req ();
  shrr_rsp_if rsp ();

  server_health_round_robin_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  shrr_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Present one request word and hold it until taken. Entered just after an
  // edge; valid stays high straight into the next word when there is no gap.
  task automatic send_word(input action_t act, input logic [IDX_W-1:0] srv);
    int gap;
    gap = draw_gap(req_calm);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.server <= srv;
    do @(posedge clk); while (!req.ready);
  endtask

  // Drop valid and wait for every outstanding word to come back.
  // The first edge lets the checker register the last accepted request.
  task automatic drain_requests();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Count writes only with the block idle; every request yields a response,
  // so an empty scoreboard means idle.
  task automatic write_count(input logic [IDX_W-1:0] value);
    drain_requests();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    live_count = (value > DEF_MAX_SERVERS) ? DEF_MAX_SERVERS : int'(value);
  endtask

  // Mostly valid indexes; some zero, some above the count, some anything.
  function automatic logic [IDX_W-1:0] draw_server();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return IDX_W'($urandom_range(0, 31));
    if (r == 1 || live_count == 0)
      return $urandom_range(0, 1) ? '0 : IDX_W'($urandom_range(live_count + 1, 31));
    return IDX_W'($urandom_range(1, live_count));
  endfunction

  function automatic action_t draw_action();
    if (err_heavy && $urandom_range(0, 1))
      return ACT_MARK_ERR;
    return action_t'($urandom_range(0, 3));
  endfunction

  // Response side: per word, a random stall with ready low, then ready high
  // until a word is taken.
  initial begin
    int stall;
    rsp.ready <= 1'b0;
    forever begin
      stall = draw_gap(rsp_calm);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [IDX_W-1:0] phase_counts [8];
    logic [IDX_W-1:0] cnt;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    req.valid  <= 1'b0;
    req.action <= ACT_MARK_ERR;
    req.server <= '0;
    req_calm   = 1'b0;
    rsp_calm   = 1'b0;
    err_heavy  = 1'b0;
    live_count = DEF_MAX_SERVERS;
    phase_counts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd8};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // --- directed: reset count of 16, all healthy, pointer zero ---
    send_word(ACT_PICK, 5'd0);        // first pick lands on server 1
    send_word(ACT_PICK, 5'd31);       // server field ignored by pick
    send_word(ACT_MARK_ERR, 5'd0);    // zero index rejected
    send_word(ACT_MARK_OK, 5'd17);    // above count rejected
    send_word(ACT_FIND_ERR, 5'd31);
    send_word(ACT_MARK_ERR, 5'd16);
    send_word(ACT_MARK_ERR, 5'd3);
    send_word(ACT_FIND_ERR, 5'd1);    // first error at 3
    send_word(ACT_FIND_ERR, 5'd16);   // scan of the last server alone
    send_word(ACT_PICK, 5'd0);        // 3 in error, skips to 4
    send_word(ACT_MARK_OK, 5'd3);
    send_word(ACT_FIND_ERR, 5'd4);    // finds 16

    // zero count: marks and finds rejected, pick finds none
    write_count(5'd0);
    send_word(ACT_MARK_ERR, 5'd1);
    send_word(ACT_FIND_ERR, 5'd1);
    send_word(ACT_PICK, 5'd0);

    // count two with pointer at 4: stale pointer wraps
    write_count(5'd2);
    send_word(ACT_MARK_ERR, 5'd1);
    send_word(ACT_PICK, 5'd0);
    send_word(ACT_MARK_ERR, 5'd2);
    send_word(ACT_PICK, 5'd0);        // everyone in error
    send_word(ACT_FIND_ERR, 5'd3);

    // saturating count; flag on 16 kept from before and seen again
    write_count(5'd31);
    send_word(ACT_FIND_ERR, 5'd3);
    send_word(ACT_PICK, 5'd0);

    write_count(5'd1);
    send_word(ACT_PICK, 5'd0);
    send_word(ACT_MARK_OK, 5'd1);
    send_word(ACT_PICK, 5'd0);

    // --- random phases ---
    for (int ph = 0; ph < 10; ph++) begin
      cnt = (ph < 8) ? phase_counts[ph] : IDX_W'($urandom_range(0, 31));
      write_count(cnt);
      req_calm  = ($urandom_range(0, 3) == 0);
      rsp_calm  = ($urandom_range(0, 3) == 0);
      err_heavy = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < 70; k++)
        send_word(draw_action(), draw_server());
    end

    drain_requests();
    repeat (24) @(posedge clk);   // catch any stray response word
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
